[src/ack_window_throughput_meter_top_macros.svh]
// Assertion macros for the ACK window throughput meter checker.
// Expects signals named clk and arst_n in the scope that uses them.
`ifndef ACK_WINDOW_THROUGHPUT_METER_TOP_MACROS_SVH
`define ACK_WINDOW_THROUGHPUT_METER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWTM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("awtm checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define AWTM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("awtm checker: next-cycle property failed");

`endif

[src/awtm_pkg.sv]
// Shared types, widths and helpers for the ACK window throughput meter.
// No dependencies; every other source file except the macros header imports this package.
`timescale 1ns / 1ps

package awtm_pkg;

	localparam int RING_DEPTH = 100;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int MIN_W      = 7;
	localparam int CMP_W      = (CNT_W > MIN_W) ? CNT_W : MIN_W;
	localparam int TSUM_W     = 32 + $clog2(RING_DEPTH);
	localparam int SSUM_W     = 16 + $clog2(RING_DEPTH);
	localparam int MUL_W      = 14;
	localparam logic [MUL_W-1:0] RATE_MUL = MUL_W'(15625);
	localparam int NUM_W      = SSUM_W + MUL_W;
	localparam int DEN_W      = TSUM_W + 1;
	localparam int KBPS_W     = 26;
	localparam logic [KBPS_W-1:0] KBPS_MAX = {KBPS_W{1'b1}};

	localparam int S_TDATA_W  = 168;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 1;
	localparam int CFG_W      = 32;

	localparam logic [MIN_W-1:0] MIN_SAMPLES_RST  = MIN_W'(5);
	localparam logic [31:0]      WINDOW_LIMIT_RST = 32'd500000;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic {
		CFG_MIN_SAMPLES  = 1'b0,
		CFG_WINDOW_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] ts;
		logic [15:0] sz;
	} ring_entry_t;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

[src/awtm_ring.sv]
// Sample ring storage: one write port, one read port, registered read data.
// Depends on awtm_pkg for depth and entry layout.
`timescale 1ns / 1ps

module awtm_ring
	import awtm_pkg::*;
(
	input  logic        clk,
	input  logic        wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ring_entry_t wr_data,
	input  logic        rd_en,
	input  logic [AW-1:0] rd_addr,
	output ring_entry_t rd_data
);

	ring_entry_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/awtm_div.sv]
// Restoring divider, one quotient bit per cycle, with 26-bit saturation.
// Depends on awtm_pkg for operand widths.
`timescale 1ns / 1ps

module awtm_div
	import awtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [KBPS_W-1:0] quot
);

	localparam int ITER_W = $clog2(NUM_W + 1);

	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  qn_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign shifted = {rem_q, qn_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(NUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			qn_q  <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			qn_q  <= {qn_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = (qn_q > NUM_W'(KBPS_MAX)) ? KBPS_MAX : qn_q[KBPS_W-1:0];

endmodule

[src/ack_window_throughput_meter_top.sv]
// Top level of the ACK window throughput meter: item decoding, ring walk and output.
// Depends on awtm_pkg, awtm_ring and awtm_div.
`timescale 1ns / 1ps

// Takes one item at a time. Start, entry and ignored items are taken without leaving
// the idle state. An end item that produces a result goes through the walk, the
// MUL step, the serial divider and the output step: the walk reads one entry per
// cycle from the ring memory port, then the divider works bit by bit through the
// 37-bit numerator (at a ring depth of 100).
// When nothing is summed the divider is skipped. A finished result sits in the
// output register while the next item is taken; a further result waits in the
// last step until that one has been taken. An end item that yields no result
// is taken without leaving the idle state.

module ack_window_throughput_meter_top
	import awtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata, from bit 0: ack_time[63:0], entry_time[127:64], seq_found[128],
	// use_echoed[129], echoed_size[145:130], recorded_size[161:146],
	// reordered[162], loss_seen[163], zero padding[167:164]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: kind[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// m_tdata, from bit 0: throughput_kbps[25:0], zero padding[31:26]
	output logic [M_TDATA_W-1:0] m_tdata,
	// m_tuser: authoritative[0]
	output logic [M_TUSER_W-1:0] m_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 cfg_wen,
	input  logic                 cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	state_t state_q, state_nxt;

	logic [MIN_W-1:0] min_samples_q;
	logic [31:0]      window_limit_q;

	logic [AW-1:0]    ws_q, ws_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [63:0]      prev_q, prev_nxt;
	logic [63:0]      pend_q, pend_nxt;
	logic [63:0]      gap_q, gap_nxt;
	logic             ign_q, ign_nxt;

	logic             accept;
	kind_t            in_kind;
	logic [63:0]      in_ack_time;
	logic [63:0]      in_entry_time;
	logic             in_found;
	logic [15:0]      in_size;
	logic             in_reordered;
	logic             in_loss;
	logic [63:0]      entry_diff;

	logic             do_push;
	logic             do_eval;
	logic             eval_ok;
	ring_entry_t      push_entry;
	logic [AW-1:0]    newest;

	logic [AW-1:0]     rd_idx_q;
	logic              rd_vld_s1;
	ring_entry_t       rd_data;
	logic              rd_en;
	logic [CNT_W-1:0]  taken_q;
	logic [TSUM_W-1:0] tsum_q;
	logic [SSUM_W-1:0] ssum_q;
	logic              loss_q;
	logic              walk_active;

	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_start;
	logic              div_done;
	logic [KBPS_W-1:0] div_quot;
	logic [KBPS_W-1:0] res_q;

	logic              out_load;
	logic              m_tvalid_q;
	logic [KBPS_W-1:0] out_kbps_q;
	logic              out_auth_q;

	assign accept        = s_tvalid && s_tready;
	assign in_kind       = kind_t'(s_tuser);
	assign in_ack_time   = s_tdata[63:0];
	assign in_entry_time = s_tdata[127:64];
	assign in_found      = s_tdata[128];
	assign in_size       = s_tdata[129] ? s_tdata[145:130] : s_tdata[161:146];
	assign in_reordered  = s_tdata[162];
	assign in_loss       = s_tdata[163];
	assign entry_diff    = gap_q - in_entry_time;

	// Item decode: next values of the ack tracking state and ring bookkeeping.
	always_comb begin
		prev_nxt   = prev_q;
		pend_nxt   = pend_q;
		gap_nxt    = gap_q;
		ign_nxt    = ign_q;
		do_push    = 1'b0;
		do_eval    = 1'b0;
		push_entry = '{ts: sat32(gap_q), sz: in_size};
		unique case (in_kind)
			KIND_START: begin
				if (in_reordered) begin
					ign_nxt = 1'b1;
				end else if (prev_q == 64'd0) begin
					prev_nxt = in_ack_time;
					ign_nxt  = 1'b1;
				end else begin
					pend_nxt = in_ack_time;
					gap_nxt  = in_ack_time - prev_q;
					ign_nxt  = 1'b0;
				end
			end
			KIND_ENTRY: begin
				if (!ign_q && in_found && entry_diff != 64'd0) begin
					do_push    = 1'b1;
					push_entry = '{ts: sat32(entry_diff), sz: in_size};
					gap_nxt    = in_entry_time;
				end
			end
			KIND_END: begin
				if (!ign_q) begin
					ign_nxt = 1'b1;
					// A non-zero gap with the packet not found ends the ack silently.
					if (gap_q == 64'd0 || in_found) begin
						do_push  = (gap_q != 64'd0);
						do_eval  = 1'b1;
						prev_nxt = pend_q;
					end
				end
			end
			default: begin
			end
		endcase
		ws_nxt  = ws_q;
		cnt_nxt = cnt_q;
		if (do_push) begin
			ws_nxt = (ws_q == AW'(RING_DEPTH - 1)) ? '0 : ws_q + AW'(1);
			if (cnt_q < CNT_W'(RING_DEPTH)) begin
				cnt_nxt = cnt_q + CNT_W'(1);
			end
		end
		newest  = (ws_nxt == '0) ? AW'(RING_DEPTH - 1) : ws_nxt - AW'(1);
		eval_ok = do_eval && (CMP_W'(cnt_nxt) >= CMP_W'(min_samples_q));
	end

	assign walk_active = (taken_q < cnt_q) && (tsum_q < TSUM_W'(window_limit_q));

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && eval_ok) state_nxt = ST_WALK;
			ST_WALK: if (!walk_active) state_nxt = ST_MUL;
			ST_MUL:  state_nxt = (tsum_q == '0) ? ST_OUT : ST_DIV;
			ST_DIV:  if (div_done) state_nxt = ST_OUT;
			ST_OUT:  if (!m_tvalid_q || m_tready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State-dependent controls.
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		rd_en     = (state_q == ST_WALK);
		div_start = (state_q == ST_MUL) && (tsum_q != '0);
		out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			min_samples_q  <= MIN_SAMPLES_RST;
			window_limit_q <= WINDOW_LIMIT_RST;
			ws_q           <= '0;
			cnt_q          <= '0;
			prev_q         <= '0;
			pend_q         <= '0;
			gap_q          <= '0;
			ign_q          <= 1'b1;
			rd_vld_s1      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == ST_WALK);
			if (cfg_wen) begin
				unique case (cfg_idx_t'(cfg_addr))
					CFG_MIN_SAMPLES:  min_samples_q  <= cfg_wdata[MIN_W-1:0];
					CFG_WINDOW_LIMIT: window_limit_q <= cfg_wdata[31:0];
				endcase
			end
			if (accept) begin
				ws_q   <= ws_nxt;
				cnt_q  <= cnt_nxt;
				prev_q <= prev_nxt;
				pend_q <= pend_nxt;
				gap_q  <= gap_nxt;
				ign_q  <= ign_nxt;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Walk datapath: reads are issued every cycle and returned data is only
	// summed while the window is still open.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && eval_ok) begin
			rd_idx_q <= newest;
			taken_q  <= '0;
			tsum_q   <= '0;
			ssum_q   <= '0;
			loss_q   <= in_loss;
		end else if (state_q == ST_WALK) begin
			rd_idx_q <= (rd_idx_q == '0) ? AW'(RING_DEPTH - 1) : rd_idx_q - AW'(1);
			if (rd_vld_s1 && walk_active) begin
				tsum_q  <= tsum_q + TSUM_W'(rd_data.ts);
				ssum_q  <= ssum_q + SSUM_W'(rd_data.sz);
				taken_q <= taken_q + CNT_W'(1);
			end
		end
		if (state_q == ST_MUL && tsum_q == '0) begin
			res_q <= (ssum_q == '0) ? '0 : KBPS_MAX;
		end else if (state_q == ST_DIV && div_done) begin
			res_q <= div_quot;
		end
		if (out_load) begin
			out_kbps_q <= res_q;
			out_auth_q <= loss_q;
		end
	end

	assign div_num = NUM_W'(ssum_q) * NUM_W'(RATE_MUL);
	assign div_den = {tsum_q, 1'b0};

	awtm_ring u_ring (
		.clk     (clk),
		.wr_en   (accept && do_push),
		.wr_addr (ws_q),
		.wr_data (push_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	awtm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - KBPS_W){1'b0}}, out_kbps_q};
	assign m_tuser  = out_auth_q;

endmodule

[src/awtm_checker.sv]
// Port-level checker for the ACK window throughput meter, bound to the top level.
// Depends on awtm_pkg and ack_window_throughput_meter_top_macros.svh.
`timescale 1ns / 1ps
`include "ack_window_throughput_meter_top_macros.svh"

module awtm_checker
	import awtm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TUSER_W-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// A result only appears after the input side has been held off.
	`AWTM_ASSERT_IMP(a_result_after_busy, $rose(m_tvalid), !$past(s_tready))

	// Start, entry and unused-kind items never stall the input side.
	`AWTM_ASSERT_NXT(a_short_item_keeps_ready, s_tvalid && s_tready && (s_tuser != KIND_END), s_tready)

	// A stalled result holds its payload.
	`AWTM_ASSERT_NXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ack_window_throughput_meter_top awtm_checker u_awtm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
